/* rtl/core/spm_pkg.sv */
package spm_pkg;

    // payload widths
    localparam int CMD_W   = 2;
    localparam int POS_W   = 12;
    localparam int PULSE_W = 15;
    localparam int DB_W    = 8;
    localparam int LIM_W   = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    // commands
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ENABLE = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PULSE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_PULSE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PULSE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CMD_LIMIT    = 3'd5;

    // reset values
    localparam logic [PULSE_W-1:0] RST_MIN_PULSE    = 15'd500;
    localparam logic [PULSE_W-1:0] RST_CENTER_PULSE = 15'd1500;
    localparam logic [PULSE_W-1:0] RST_MAX_PULSE    = 15'd2500;
    localparam logic [PULSE_W-1:0] RST_PERIOD       = 15'd20000;
    localparam logic [DB_W-1:0]    RST_DEADBAND     = 8'd4;
    localparam logic [LIM_W-1:0]   RST_CMD_LIMIT    = 10'd150;

    localparam logic [LIM_W-1:0]   FULL_SCALE = 10'd1000;
    localparam logic [PULSE_W-1:0] PULSE_MAX  = 15'd32767;

    // floor(n / 1000) = (n * RECIP_1000) >> RECIP_SHIFT, exact for n < 2^25
    localparam int              RECIP_SHIFT = 36;
    localparam logic [26:0]     RECIP_1000  = 27'd68719477;
    localparam logic [24:0]     ROUND_UP_1000 = 25'd999;

    typedef logic [CMD_W-1:0]   cmd_t;
    typedef logic [PULSE_W-1:0] pulse_t;

endpackage

/* rtl/core/servo_pwm_position_driver.sv */
// A result beat appears on m_ once its input beat has passed through every register stage below.
// Throughput: one beat per cycle; five register stages (input, product, quotient,
//   width, result) each stall only when the stage after them is full and blocked.
// Reset (aresetn low, synchronous): pipeline emptied, registers to defaults,
//   counter 0, compare values 1500, output enabled, waveform state low.
module servo_pwm_position_driver (
    input  logic                         aclk,
    input  logic                         aresetn,
    // configuration writes
    input  logic                         cfg_wr_en,
    input  logic [spm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [spm_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // command channel
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [spm_pkg::CMD_W-1:0]    s_cmd,
    input  logic signed [spm_pkg::POS_W-1:0] s_position_tenths,
    input  logic                         s_enable,
    // result channel
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_pwm_level,
    output logic [spm_pkg::PULSE_W-1:0]  m_pulse_width,
    output logic                         m_applied,
    output logic                         m_enabled
);
    import spm_pkg::*;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    pulse_t           min_pulse_reg, center_pulse_reg, max_pulse_reg, period_reg;
    logic [DB_W-1:0]  deadband_reg;
    logic [LIM_W-1:0] cmd_limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_pulse_reg    <= RST_MIN_PULSE;
            center_pulse_reg <= RST_CENTER_PULSE;
            max_pulse_reg    <= RST_MAX_PULSE;
            period_reg       <= RST_PERIOD;
            deadband_reg     <= RST_DEADBAND;
            cmd_limit_reg    <= RST_CMD_LIMIT;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_MIN_PULSE:    min_pulse_reg    <= cfg_wdata;
                REG_CENTER_PULSE: center_pulse_reg <= cfg_wdata;
                REG_MAX_PULSE:    max_pulse_reg    <= cfg_wdata;
                REG_PERIOD:       period_reg       <= cfg_wdata;
                REG_DEADBAND:     deadband_reg     <= cfg_wdata[DB_W-1:0];
                REG_CMD_LIMIT:    cmd_limit_reg    <= cfg_wdata[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Pipeline flow control: a stage loads when empty or when it drains
    // ---------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, m_valid_reg;
    logic rdy_out, rdy4, rdy3, rdy2, rdy1;
    logic fire4;

    assign rdy_out = !m_valid_reg || m_ready;
    assign rdy4    = !v4_reg || rdy_out;
    assign rdy3    = !v3_reg || rdy4;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign fire4   = v4_reg && rdy_out;
    assign s_ready = rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (rdy1)    v1_reg      <= s_valid;
            if (rdy2)    v2_reg      <= v1_reg;
            if (rdy3)    v3_reg      <= v2_reg;
            if (rdy4)    v4_reg      <= v3_reg;
            if (rdy_out) m_valid_reg <= v4_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: input register; saturate position, form |pos| * |span|
    // ---------------------------------------------------------------
    cmd_t                    cmd1_reg;
    logic signed [POS_W-1:0] pos1_reg;
    logic                    en1_reg;

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            cmd1_reg <= s_cmd;
            pos1_reg <= s_position_tenths;
            en1_reg  <= s_enable;
        end
    end

    logic [LIM_W-1:0]   lim;
    logic               pos_neg;
    logic [POS_W-1:0]   pos_abs;
    logic [LIM_W-1:0]   mag;
    logic [PULSE_W:0]   span;
    logic               span_neg;
    logic [PULSE_W-1:0] span_abs;
    logic [24:0]        prod1;

    always_comb begin
        lim      = (cmd_limit_reg > FULL_SCALE) ? FULL_SCALE : cmd_limit_reg;
        pos_neg  = pos1_reg[POS_W-1];
        pos_abs  = pos_neg ? POS_W'(-pos1_reg) : POS_W'(pos1_reg);
        mag      = (pos_abs > {2'b00, lim}) ? lim : pos_abs[LIM_W-1:0];
        // negative side scales by (center - min), positive by (max - center)
        span     = pos_neg ? ({1'b0, center_pulse_reg} - {1'b0, min_pulse_reg})
                           : ({1'b0, max_pulse_reg} - {1'b0, center_pulse_reg});
        span_neg = span[PULSE_W];
        span_abs = span_neg ? PULSE_W'(-span) : span[PULSE_W-1:0];
        prod1    = {15'd0, mag} * {10'd0, span_abs};
    end

    // ---------------------------------------------------------------
    // Stage 2: floor division by 1000 via reciprocal
    // ---------------------------------------------------------------
    cmd_t        cmd2_reg;
    logic        en2_reg, neg2_reg, xneg2_reg;
    logic [24:0] u2_reg;

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            cmd2_reg  <= cmd1_reg;
            en2_reg   <= en1_reg;
            neg2_reg  <= pos_neg;
            xneg2_reg <= span_neg;
            u2_reg    <= prod1;
        end
    end

    logic [24:0]        num2;
    logic [51:0]        recip_prod;
    logic [15:0]        quot2;
    logic signed [16:0] fdiv2;

    always_comb begin
        // negative dividend rounds toward minus infinity: ceil of magnitude
        num2       = u2_reg + (xneg2_reg ? ROUND_UP_1000 : 25'd0);
        recip_prod = {27'd0, num2} * {25'd0, RECIP_1000};
        quot2      = recip_prod[RECIP_SHIFT+15:RECIP_SHIFT];
        fdiv2      = xneg2_reg ? -$signed({1'b0, quot2}) : $signed({1'b0, quot2});
    end

    // ---------------------------------------------------------------
    // Stage 3: apply offset around centre and clamp
    // ---------------------------------------------------------------
    cmd_t               cmd3_reg;
    logic               en3_reg, neg3_reg;
    logic signed [16:0] f3_reg;

    always_ff @(posedge aclk) begin
        if (rdy3) begin
            cmd3_reg <= cmd2_reg;
            en3_reg  <= en2_reg;
            neg3_reg <= neg2_reg;
            f3_reg   <= fdiv2;
        end
    end

    logic signed [17:0] cen_x, off_x, w_wide;
    pulse_t             w3;

    always_comb begin
        cen_x  = $signed({3'b000, center_pulse_reg});
        off_x  = {f3_reg[16], f3_reg};
        w_wide = neg3_reg ? (cen_x - off_x) : (cen_x + off_x);
        if (w_wide[17])
            w3 = '0;
        else if (w_wide > $signed({3'b000, PULSE_MAX}))
            w3 = PULSE_MAX;
        else
            w3 = w_wide[PULSE_W-1:0];
    end

    // ---------------------------------------------------------------
    // Stage 4: width register; state update happens as it drains
    // ---------------------------------------------------------------
    cmd_t   cmd4_reg;
    logic   en4_reg;
    pulse_t w4_reg;

    always_ff @(posedge aclk) begin
        if (rdy4) begin
            cmd4_reg <= cmd3_reg;
            en4_reg  <= en3_reg;
            w4_reg   <= w3;
        end
    end

    // generator state
    pulse_t tick_reg, pending_reg, active_reg, last_reg;
    logic   out_en_reg, wave_reg;
    pulse_t tick_next, pending_next, active_next, last_next;
    logic   out_en_next, wave_next, applied_next;

    logic [PULSE_W:0]   tick_inc;
    pulse_t             per;
    logic [PULSE_W:0]   diff;
    pulse_t             dabs;

    always_comb begin
        tick_next    = tick_reg;
        pending_next = pending_reg;
        active_next  = active_reg;
        last_next    = last_reg;
        out_en_next  = out_en_reg;
        wave_next    = wave_reg;
        applied_next = 1'b0;

        per      = (period_reg == '0) ? PULSE_W'(1) : period_reg;
        tick_inc = {1'b0, tick_reg} + (PULSE_W+1)'(1);
        diff     = {1'b0, w4_reg} - {1'b0, last_reg};
        dabs     = diff[PULSE_W] ? PULSE_W'(-diff) : diff[PULSE_W-1:0];

        case (cmd4_reg)
            CMD_TICK: begin
                // frame start latches the pending width; match beats start
                if (tick_reg == '0) begin
                    active_next = pending_reg;
                    wave_next   = 1'b1;
                end
                if (tick_reg == active_next)
                    wave_next = 1'b0;
                if (tick_inc >= {1'b0, per})
                    tick_next = '0;
                else
                    tick_next = tick_inc[PULSE_W-1:0];
            end
            CMD_WRITE: begin
                out_en_next = 1'b1;
                if (dabs >= {7'd0, deadband_reg}) begin
                    pending_next = w4_reg;
                    last_next    = w4_reg;
                    applied_next = 1'b1;
                end
            end
            CMD_ENABLE: begin
                out_en_next = en4_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg    <= '0;
            pending_reg <= RST_CENTER_PULSE;
            active_reg  <= RST_CENTER_PULSE;
            last_reg    <= RST_CENTER_PULSE;
            out_en_reg  <= 1'b1;
            wave_reg    <= 1'b0;
        end else if (fire4) begin
            tick_reg    <= tick_next;
            pending_reg <= pending_next;
            active_reg  <= active_next;
            last_reg    <= last_next;
            out_en_reg  <= out_en_next;
            wave_reg    <= wave_next;
        end
    end

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    logic   pwm_reg, applied_reg, enabled_reg;
    pulse_t pulse_reg;

    always_ff @(posedge aclk) begin
        if (fire4) begin
            pwm_reg     <= wave_next & out_en_next;
            pulse_reg   <= last_next;
            applied_reg <= applied_next;
            enabled_reg <= out_en_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_pwm_level   = pwm_reg;
    assign m_pulse_width = pulse_reg;
    assign m_applied     = applied_reg;
    assign m_enabled     = enabled_reg;

endmodule
